// ===== rtl/bwd_pkg.sv =====
// Package for the boundary wave damping block: request/result structs,
// register map and fixed-point constants. No dependencies.
package bwd_pkg;

	localparam int unsigned FracIn  = 3120;
	localparam int unsigned FracOut = 12452;
	localparam int unsigned TauCoef = 2184;
	localparam int unsigned DivBits = 31;
	localparam int unsigned SqrtBits = 24;

	localparam logic [2:0] REG_Y_MIN       = 3'd0;
	localparam logic [2:0] REG_Y_MAX       = 3'd1;
	localparam logic [2:0] REG_TIME_STEP   = 3'd2;
	localparam logic [2:0] REG_OMEGA_SHIFT = 3'd3;
	localparam logic [2:0] REG_DAMP_AZ     = 3'd4;
	localparam logic [2:0] REG_DAMP_DENS   = 3'd5;

	typedef struct packed {
		logic [30:0]        radius;
		logic signed [31:0] vx_in;
		logic signed [31:0] vy_in;
		logic [30:0]        dens_in;
		logic signed [31:0] vx_ref;
		logic signed [31:0] vy_ref;
		logic [30:0]        dens_ref;
	} req_t;

	typedef struct packed {
		logic signed [31:0] vx_out;
		logic signed [31:0] vy_out;
		logic [30:0]        dens_out;
		logic               in_zone;
	} res_t;

endpackage

// ===== rtl/boundary_wave_damping.sv =====
// Top level of the boundary wave damping block: APB registers and a
// fixed-latency pipeline. Depends on bwd_pkg.
//
// channel   | signals                     | handshake
// request   | start, busy, req            | accepted when start && !busy
// result    | done, res                   | one cycle, cannot be held off
// config    | psel..pready, prdata        | APB, pready tied high
//
// One request per cycle. The path from the accepting edge to the edge that
// takes the result runs through two zone stages, 31 stages of the x divider
// with the square root alongside, two multiply stages, 31 stages of the weight
// divider and four output stages. busy is always low.
// Reset clears registers to defaults and empties the valid chain.
module boundary_wave_damping (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bwd_pkg::req_t       req,
	output logic                done,
	output bwd_pkg::res_t       res,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int DW = bwd_pkg::DivBits;
	localparam int SW = bwd_pkg::SqrtBits;

	logic [30:0] y_min_q, y_max_q, time_step_q;
	logic signed [31:0] omega_q;
	logic damp_az_q, damp_dens_q;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_min_q <= 31'd32768;
			y_max_q <= 31'd163840;
			time_step_q <= 31'd66;
			omega_q <= '0;
			damp_az_q <= 1'b1;
			damp_dens_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				bwd_pkg::REG_Y_MIN:       y_min_q <= pwdata[30:0];
				bwd_pkg::REG_Y_MAX:       y_max_q <= pwdata[30:0];
				bwd_pkg::REG_TIME_STEP:   time_step_q <= pwdata[30:0];
				bwd_pkg::REG_OMEGA_SHIFT: omega_q <= pwdata;
				bwd_pkg::REG_DAMP_AZ:     damp_az_q <= pwdata[0];
				bwd_pkg::REG_DAMP_DENS:   damp_dens_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			bwd_pkg::REG_Y_MIN:       prdata = {1'b0, y_min_q};
			bwd_pkg::REG_Y_MAX:       prdata = {1'b0, y_max_q};
			bwd_pkg::REG_TIME_STEP:   prdata = {1'b0, time_step_q};
			bwd_pkg::REG_OMEGA_SHIFT: prdata = omega_q;
			bwd_pkg::REG_DAMP_AZ:     prdata = {31'd0, damp_az_q};
			bwd_pkg::REG_DAMP_DENS:   prdata = {31'd0, damp_dens_q};
			default:                  prdata = '0;
		endcase
	end

	// stage 1: zone bounds
	logic v_s1;
	bwd_pkg::req_t r_s1;
	logic ok_s1;
	logic [30:0] span_c;
	logic [46:0] pin_s1, pout_s1;
	assign span_c = y_max_q - y_min_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		r_s1 <= req;
		ok_s1 <= y_max_q > y_min_q;
		pin_s1 <= 47'(span_c) * 47'(bwd_pkg::FracIn);
		pout_s1 <= 47'(span_c) * 47'(bwd_pkg::FracOut);
	end

	// stage 2: zone test, depth and width
	logic [31:0] yinf_c, ysup_c;
	assign yinf_c = 32'(y_min_q) + 32'(pin_s1[46:16]);
	assign ysup_c = 32'(y_max_q) - 32'(pout_s1[46:16]);
	logic v_s2, zone_s2;
	bwd_pkg::req_t r_s2;
	logic [31:0] depth_s2, width_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		r_s2 <= r_s1;
		if (ok_s1 && 32'(r_s1.radius) < yinf_c) begin
			zone_s2 <= 1'b1;
			depth_s2 <= yinf_c - 32'(r_s1.radius);
			width_s2 <= yinf_c - 32'(y_min_q);
		end else if (ok_s1 && 32'(r_s1.radius) > ysup_c) begin
			zone_s2 <= 1'b1;
			depth_s2 <= 32'(r_s1.radius) - ysup_c;
			width_s2 <= 32'(y_max_q) - ysup_c;
		end else begin
			zone_s2 <= 1'b0;
			depth_s2 <= '0;
			width_s2 <= '0;
		end
	end

	// x = min(depth*2^16/width, 1.0): saturate up front when width is zero or depth >= width,
	// else hold depth for 15 stages and take 16 restoring quotient steps.
	logic [DW:0] dv_v;
	bwd_pkg::req_t dv_r [DW+1];
	logic dv_z [DW+1];
	logic dv_sat [DW+1];
	logic [47:0] dv_rem [DW+1];
	logic [31:0] dv_den [DW+1];
	logic [16:0] dv_q [DW+1];
	// sqrt pipeline runs alongside on radius<<16 (47 bits), SW stages of 2 bits
	logic [47:0] sq_v [DW+1];
	logic [23:0] sq_res [DW+1];
	logic [25:0] sq_rem [DW+1];

	always_comb begin
		dv_v[0] = v_s2;
		dv_r[0] = r_s2;
		dv_z[0] = zone_s2;
		dv_sat[0] = (width_s2 == 32'd0) || (depth_s2 >= width_s2);
		dv_rem[0] = 48'(depth_s2);
		dv_den[0] = width_s2;
		dv_q[0] = '0;
		sq_v[0] = {1'b0, r_s2.radius, 16'd0};
		sq_res[0] = '0;
		sq_rem[0] = '0;
	end

	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [47:0] tr;
		logic [25:0] st, tt;
		assign tr = {dv_rem[k][46:0], 1'b0};
		assign st = {sq_rem[k][23:0], sq_v[k][47:46]};
		assign tt = {sq_res[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k+1] <= 1'b0;
			else dv_v[k+1] <= dv_v[k];
		end
		always_ff @(posedge clk) begin
			dv_r[k+1] <= dv_r[k];
			dv_z[k+1] <= dv_z[k];
			dv_sat[k+1] <= dv_sat[k];
			dv_den[k+1] <= dv_den[k];
			if (k >= 15) begin
				if (tr >= 48'(dv_den[k])) begin
					dv_rem[k+1] <= tr - 48'(dv_den[k]);
					dv_q[k+1] <= {dv_q[k][15:0], 1'b1};
				end else begin
					dv_rem[k+1] <= tr;
					dv_q[k+1] <= {dv_q[k][15:0], 1'b0};
				end
			end else begin
				dv_rem[k+1] <= dv_rem[k];
				dv_q[k+1] <= dv_q[k];
			end
			sq_v[k+1] <= sq_v[k] << 2;
			if (k < SW) begin
				if (st >= tt) begin
					sq_rem[k+1] <= st - tt;
					sq_res[k+1] <= {sq_res[k][22:0], 1'b1};
				end else begin
					sq_rem[k+1] <= st;
					sq_res[k+1] <= {sq_res[k][22:0], 1'b0};
				end
			end else begin
				sq_rem[k+1] <= sq_rem[k];
				sq_res[k+1] <= sq_res[k];
			end
		end
	end

	// stage A: ramp = x^2 >> 16, p = r*s >> 16
	logic vA;
	bwd_pkg::req_t rA;
	logic zA;
	logic [16:0] rampA;
	logic [54:0] pfullA;
	logic [16:0] xq;
	assign xq = dv_sat[DW] ? 17'h10000 : dv_q[DW];
	logic [33:0] xx;
	assign xx = 34'(xq) * 34'(xq);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vA <= 1'b0;
		else vA <= dv_v[DW];
	end
	always_ff @(posedge clk) begin
		rA <= dv_r[DW];
		zA <= dv_z[DW];
		rampA <= xx[32:16];
		pfullA <= 55'(dv_r[DW].radius) * 55'(sq_res[DW]);
	end

	// stage B: tau and w
	logic vB;
	bwd_pkg::req_t rB;
	logic zB, rnzB;
	logic [54:0] tauprodB;
	logic [47:0] wprodB;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vB <= 1'b0;
		else vB <= vA;
	end
	always_ff @(posedge clk) begin
		rB <= rA;
		zB <= zA;
		rnzB <= rampA != 17'd0;
		tauprodB <= 55'(pfullA[54:16]) * 55'(bwd_pkg::TauCoef);
		wprodB <= 48'(time_step_q) * 48'(rampA);
	end

	// stage C: sum; then f = w*2^30/sum over 31 quotient bits
	logic [36:0] tauC, wC;
	assign tauC = 37'(tauprodB[54:16]);
	assign wC = 37'(wprodB[47:16]);
	localparam int FW = 31;
	logic [FW:0] fv;
	bwd_pkg::req_t fr [FW+1];
	logic fz [FW+1];
	logic fok [FW+1];
	logic [37:0] frem [FW+1];
	logic [36:0] fden [FW+1];
	logic [30:0] fq [FW+1];
	logic [37:0] fsh [FW+1];
	always_comb begin
		fv[0] = vB;
		fr[0] = rB;
		fz[0] = zB;
		fok[0] = rnzB && ((tauC + wC) != 37'd0);
		fden[0] = tauC + wC;
		// w < 2^32 and sum >= w: remainder starts at zero and w enters at the first step
		frem[0] = '0;
		fsh[0] = 38'(wC);
		fq[0] = '0;
	end
	for (genvar k = 0; k < FW; k++) begin : g_f
		logic [37:0] tr;
		// long division of w*2^30: first 1 step brings w in, rest shift zeros
		assign tr = (k == 0) ? fsh[k] : {frem[k][36:0], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) fv[k+1] <= 1'b0;
			else fv[k+1] <= fv[k];
		end
		always_ff @(posedge clk) begin
			fr[k+1] <= fr[k];
			fz[k+1] <= fz[k];
			fok[k+1] <= fok[k];
			fden[k+1] <= fden[k];
			fsh[k+1] <= fsh[k];
			if (tr >= 38'(fden[k])) begin
				frem[k+1] <= tr - 38'(fden[k]);
				fq[k+1] <= {fq[k][29:0], 1'b1};
			end else begin
				frem[k+1] <= tr;
				fq[k+1] <= {fq[k][29:0], 1'b0};
			end
		end
	end

	// stage D: targets and differences
	logic vD;
	bwd_pkg::req_t rD;
	logic zD, okD;
	logic [30:0] fD;
	logic signed [63:0] omD;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vD <= 1'b0;
		else vD <= fv[FW];
	end
	always_ff @(posedge clk) begin
		rD <= fr[FW];
		zD <= fz[FW];
		okD <= fok[FW];
		fD <= fq[FW];
		omD <= 64'(omega_q) * $signed({33'd0, fr[FW].radius});
	end

	logic signed [33:0] vxt_c;
	logic signed [47:0] shf_c;
	assign shf_c = 48'(omD >>> 16);
	always_comb begin
		logic signed [48:0] d;
		d = 49'(rD.vx_ref) - 49'(shf_c);
		if (d > 49'sd2147483647) vxt_c = 34'sd2147483647;
		else if (d < -49'sd2147483648) vxt_c = -34'sd2147483648;
		else vxt_c = 34'(d);
	end

	logic vE;
	bwd_pkg::req_t rE;
	logic zE, okE;
	logic signed [33:0] dvxE, dvyE, ddnE;
	logic [30:0] fE;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vE <= 1'b0;
		else vE <= vD;
	end
	always_ff @(posedge clk) begin
		rE <= rD;
		zE <= zD;
		okE <= okD;
		fE <= fD;
		dvxE <= vxt_c - 34'(rD.vx_in);
		dvyE <= 34'(rD.vy_ref) - 34'(rD.vy_in);
		ddnE <= $signed({3'd0, rD.dens_ref}) - $signed({3'd0, rD.dens_in});
	end

	// stage F: products
	logic vF;
	bwd_pkg::req_t rF;
	logic zF, okF;
	logic signed [65:0] pxF, pyF, pdF;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vF <= 1'b0;
		else vF <= vE;
	end
	always_ff @(posedge clk) begin
		rF <= rE;
		zF <= zE;
		okF <= okE;
		pxF <= 66'(dvxE) * $signed({35'd0, fE});
		pyF <= 66'(dvyE) * $signed({35'd0, fE});
		pdF <= 66'(ddnE) * $signed({35'd0, fE});
	end

	// stage G: add, saturate, select
	logic signed [36:0] nx, ny, nd;
	assign nx = 37'(rF.vx_in) + 37'(pxF >>> 30);
	assign ny = 37'(rF.vy_in) + 37'(pyF >>> 30);
	assign nd = $signed({6'd0, rF.dens_in}) + 37'(pdF >>> 30);

	logic v_out_q;
	bwd_pkg::res_t res_c;
	bwd_pkg::res_t res_q;
	always_comb begin
		res_c.in_zone = zF;
		res_c.vx_out = rF.vx_in;
		res_c.vy_out = rF.vy_in;
		res_c.dens_out = rF.dens_in;
		if (zF && okF) begin
			if (damp_az_q) begin
				if (nx > 37'sd2147483647) res_c.vx_out = 32'h7FFFFFFF;
				else if (nx < -37'sd2147483648) res_c.vx_out = 32'h80000000;
				else res_c.vx_out = 32'(nx);
			end
			if (ny > 37'sd2147483647) res_c.vy_out = 32'h7FFFFFFF;
			else if (ny < -37'sd2147483648) res_c.vy_out = 32'h80000000;
			else res_c.vy_out = 32'(ny);
			if (damp_dens_q) begin
				if (nd > 37'sd2147483647) res_c.dens_out = 31'h7FFFFFFF;
				else if (nd < 37'sd0) res_c.dens_out = 31'd0;
				else res_c.dens_out = 31'(nd);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out_q <= 1'b0;
		else v_out_q <= vF;
	end
	always_ff @(posedge clk) begin
		res_q <= res_c;
	end

	assign done = v_out_q;
	assign res = res_q;
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for boundary_wave_damping: a directed table, then random
// cells over several register settings, checked against typed table values or a
// local predictor. Depends on bwd_pkg and the boundary_wave_damping RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DRAIN_CYCLES = 150;
	localparam int unsigned STALL_LIMIT  = 5000;
	localparam longint unsigned ONE_Q16  = 64'd65536;

	typedef struct {
		bit            reg_write;
		logic [2:0]    reg_idx;
		logic [31:0]   reg_val;
		bwd_pkg::req_t stim;
		bit            typed;
		bwd_pkg::res_t want;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	bwd_pkg::req_t req;
	logic          done;
	bwd_pkg::res_t res;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [4:0]    paddr;
	logic [31:0]   pwdata;
	logic [31:0]   prdata;
	logic          pready;

	logic [30:0]        cfg_y_min;
	logic [30:0]        cfg_y_max;
	logic [30:0]        cfg_time_step;
	logic signed [31:0] cfg_omega;
	bit                 cfg_damp_az;
	bit                 cfg_damp_dens;

	bwd_pkg::res_t damped_q[$];
	row_t          cell_table[$];
	bit            typed_now;
	bwd_pkg::res_t typed_val;
	bit            no_idle;
	int            fail_count;
	int            stall_count;

	boundary_wave_damping u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint relax(longint old, longint tgt, longint unsigned f);
		longint prod;
		prod = (tgt - old) * longint'(f);
		return old + (prod >>> 30);
	endfunction

	function automatic longint unsigned inner_edge();
		longint unsigned span;
		span = longint'(cfg_y_max) - longint'(cfg_y_min);
		return longint'(cfg_y_min) + ((span * bwd_pkg::FracIn) >> 16);
	endfunction

	function automatic longint unsigned outer_edge();
		longint unsigned span;
		span = longint'(cfg_y_max) - longint'(cfg_y_min);
		return longint'(cfg_y_max) - ((span * bwd_pkg::FracOut) >> 16);
	endfunction

	function automatic bwd_pkg::res_t damp_cell(bwd_pkg::req_t q);
		longint unsigned r, yinf, ysup, depth, width, x, ramp, s, p, tau, w, sum, f;
		longint vx, vy, dn, vx_t, vy_t, dn_t, shift, vx_goal;
		bit zone;
		bwd_pkg::res_t o;
		r = longint'(q.radius);
		vx = longint'(signed'(q.vx_in));
		vy = longint'(signed'(q.vy_in));
		dn = longint'(q.dens_in);
		vx_t = longint'(signed'(q.vx_ref));
		vy_t = longint'(signed'(q.vy_ref));
		dn_t = longint'(q.dens_ref);
		zone = 1'b0;
		depth = 0;
		width = 0;
		o.vx_out = q.vx_in;
		o.vy_out = q.vy_in;
		o.dens_out = q.dens_in;
		if (cfg_y_max > cfg_y_min) begin
			yinf = inner_edge();
			ysup = outer_edge();
			if (r < yinf) begin
				zone = 1'b1;
				depth = yinf - r;
				width = yinf - longint'(cfg_y_min);
			end else if (r > ysup) begin
				zone = 1'b1;
				depth = r - ysup;
				width = longint'(cfg_y_max) - ysup;
			end
		end
		if (zone) begin
			if (width == 0) begin
				x = ONE_Q16;
			end else begin
				x = (depth << 16) / width;
				if (x > ONE_Q16)
					x = ONE_Q16;
			end
			ramp = (x * x) >> 16;
			s = isqrt(r << 16);
			p = (r * s) >> 16;
			tau = (p * bwd_pkg::TauCoef) >> 16;
			w = (longint'(cfg_time_step) * ramp) >> 16;
			sum = tau + w;
			if (ramp != 0 && sum != 0) begin
				f = (w << 30) / sum;
				shift = (longint'(cfg_omega) * longint'(r)) >>> 16;
				vx_goal = clamp(vx_t - shift, -64'sd2147483648, 64'sd2147483647);
				if (cfg_damp_az)
					o.vx_out = 32'(clamp(relax(vx, vx_goal, f),
						-64'sd2147483648, 64'sd2147483647));
				o.vy_out = 32'(clamp(relax(vy, vy_t, f),
					-64'sd2147483648, 64'sd2147483647));
				if (cfg_damp_dens)
					o.dens_out = 31'(clamp(relax(dn, dn_t, f), 0, 64'sd2147483647));
			end
		end
		o.in_zone = zone;
		return o;
	endfunction

	always @(posedge clk) begin
		bwd_pkg::res_t want;
		if (arst_n) begin
			if (start && !busy)
				damped_q.push_back(typed_now ? typed_val : damp_cell(req));
			if (done) begin
				if (damped_q.size() == 0) begin
					$error("unexpected result vx_out=%0d", res.vx_out);
					fail_count++;
				end else begin
					want = damped_q.pop_front();
					if (res.vx_out !== want.vx_out) begin
						$error("vx_out expected %0d actual %0d", want.vx_out, res.vx_out);
						fail_count++;
					end
					if (res.vy_out !== want.vy_out) begin
						$error("vy_out expected %0d actual %0d", want.vy_out, res.vy_out);
						fail_count++;
					end
					if (res.dens_out !== want.dens_out) begin
						$error("dens_out expected %0d actual %0d", want.dens_out,
							res.dens_out);
						fail_count++;
					end
					if (res.in_zone !== want.in_zone) begin
						$error("in_zone expected %0d actual %0d", want.in_zone, res.in_zone);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			bwd_pkg::REG_Y_MIN:       cfg_y_min = val[30:0];
			bwd_pkg::REG_Y_MAX:       cfg_y_max = val[30:0];
			bwd_pkg::REG_TIME_STEP:   cfg_time_step = val[30:0];
			bwd_pkg::REG_OMEGA_SHIFT: cfg_omega = val;
			bwd_pkg::REG_DAMP_AZ:     cfg_damp_az = val[0];
			bwd_pkg::REG_DAMP_DENS:   cfg_damp_dens = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (damped_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_cell(bwd_pkg::req_t q, bit typed, bwd_pkg::res_t want);
		while (!no_idle && $urandom_range(0, 99) < 34) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		typed_now = typed;
		typed_val = want;
		start <= 1'b1;
		req <= q;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_radius();
		longint unsigned yinf, ysup, top;
		yinf = inner_edge();
		ysup = outer_edge();
		if (cfg_y_max <= cfg_y_min)
			return 31'(rand_word());
		case ($urandom_range(0, 9))
			0, 1, 2: return 31'($urandom_range(0, 32'(yinf)));
			3, 4, 5, 6: begin
				top = longint'(cfg_y_max) + (longint'(cfg_y_max) - ysup);
				if (top > 64'h7fff_ffff)
					top = 64'h7fff_ffff;
				return 31'($urandom_range(32'(ysup), 32'(top)));
			end
			7: return 31'($urandom_range(cfg_y_min, cfg_y_max));
			8: return 31'(cfg_y_min + $urandom_range(0, 2) - 1);
			default: return 31'(rand_word());
		endcase
	endfunction

	function automatic bwd_pkg::req_t rand_cell();
		bwd_pkg::req_t q;
		q.radius = rand_radius();
		q.vx_in = rand_word();
		q.vy_in = rand_word();
		q.dens_in = 31'(rand_word());
		q.vx_ref = rand_word();
		q.vy_ref = rand_word();
		q.dens_ref = 31'(rand_word());
		return q;
	endfunction

	function automatic bwd_pkg::req_t mk_cell(logic [30:0] r, logic [31:0] a,
		logic [31:0] b, logic [30:0] c, logic [31:0] d, logic [31:0] e, logic [30:0] g);
		bwd_pkg::req_t q;
		q = '{r, a, b, c, d, e, g};
		return q;
	endfunction

	function automatic void add_cell(bwd_pkg::req_t q, bit typed, bwd_pkg::res_t want);
		row_t row;
		row.reg_write = 1'b0;
		row.reg_idx = '0;
		row.reg_val = '0;
		row.stim = q;
		row.typed = typed;
		row.want = want;
		cell_table.push_back(row);
	endfunction

	function automatic void add_reg(logic [2:0] idx, logic [31:0] val);
		row_t row;
		row.reg_write = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		row.stim = '0;
		row.typed = 1'b0;
		row.want = '0;
		cell_table.push_back(row);
	endfunction

	function automatic void build_table();
		bwd_pkg::req_t q;
		q = mk_cell(31'd98304, 32'd12345, -32'sd777, 31'd65536, 32'd1, 32'd2, 31'd3);
		add_cell(q, 1'b1, '{q.vx_in, q.vy_in, q.dens_in, 1'b0});
		q = mk_cell(31'd0, 32'h8000_0000, 32'h7fff_ffff, 31'd0,
			32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
		add_cell(q, 1'b1, '{q.vx_ref, q.vy_ref, q.dens_ref, 1'b1});
		q = mk_cell(31'd0, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 31'd0);
		add_cell(q, 1'b1, '{q.vx_ref, q.vy_ref, q.dens_ref, 1'b1});
		q = mk_cell(31'd39008, 32'd5, 32'd6, 31'd7, 32'd8, 32'd9, 31'd10);
		add_cell(q, 1'b1, '{q.vx_in, q.vy_in, q.dens_in, 1'b0});
		q = mk_cell(31'd138936, 32'd5, 32'd6, 31'd7, 32'd8, 32'd9, 31'd10);
		add_cell(q, 1'b1, '{q.vx_in, q.vy_in, q.dens_in, 1'b0});
		add_cell(mk_cell(31'd39007, 32'h8000_0000, 32'h7fff_ffff, 31'd0,
			32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff), 1'b0, '0);
		add_cell(mk_cell(31'd138937, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 31'd0), 1'b0, '0);
		add_cell(mk_cell(31'd32768, 32'd100, -32'sd100, 31'd200, 32'd0, 32'd0, 31'd0),
			1'b0, '0);
		add_cell(mk_cell(31'd163840, 32'd100, -32'sd100, 31'd200, 32'd0, 32'd0, 31'd0),
			1'b0, '0);
		add_cell(mk_cell(31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 31'd0), 1'b0, '0);
		add_reg(bwd_pkg::REG_DAMP_AZ, 32'd0);
		add_reg(bwd_pkg::REG_DAMP_DENS, 32'd0);
		add_reg(bwd_pkg::REG_OMEGA_SHIFT, 32'h8000_0000);
		q = mk_cell(31'd0, 32'd11, 32'd22, 31'd33, 32'd44, 32'd55, 31'd66);
		add_cell(q, 1'b1, '{q.vx_in, q.vy_ref, q.dens_in, 1'b1});
		add_cell(mk_cell(31'd150000, 32'd11, 32'd22, 31'd33, 32'd44, 32'd55, 31'd66),
			1'b0, '0);
		add_reg(bwd_pkg::REG_DAMP_AZ, 32'd1);
		add_cell(mk_cell(31'd20000, 32'd0, 32'd0, 31'd0, 32'h7fff_0000, 32'd0, 31'd0),
			1'b0, '0);
		add_reg(bwd_pkg::REG_Y_MIN, 32'd163840);
		add_reg(bwd_pkg::REG_Y_MAX, 32'd163840);
		q = mk_cell(31'd0, 32'd1, 32'd2, 31'd3, 32'd4, 32'd5, 31'd6);
		add_cell(q, 1'b1, '{q.vx_in, q.vy_in, q.dens_in, 1'b0});
		add_reg(bwd_pkg::REG_Y_MAX, 32'd163841);
		add_cell(mk_cell(31'd100, 32'd1, 32'd2, 31'd3, 32'd400, 32'd500, 31'd600),
			1'b0, '0);
		add_reg(bwd_pkg::REG_TIME_STEP, 32'd0);
		add_cell(mk_cell(31'd100, 32'd1, 32'd2, 31'd3, 32'd400, 32'd500, 31'd600),
			1'b0, '0);
	endfunction

	initial begin
		int ph;
		int n;
		row_t row;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_now = 1'b0;
		typed_val = '0;
		no_idle = 1'b0;
		fail_count = 0;
		stall_count = 0;
		cfg_y_min = 31'd32768;
		cfg_y_max = 31'd163840;
		cfg_time_step = 31'd66;
		cfg_omega = 32'sd0;
		cfg_damp_az = 1'b1;
		cfg_damp_dens = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		build_table();
		foreach (cell_table[i]) begin
			row = cell_table[i];
			if (row.reg_write) begin
				@(negedge clk);
				start <= 1'b0;
				drain();
				reg_write(row.reg_idx, row.reg_val);
			end else begin
				send_cell(row.stim, row.typed, row.want);
			end
		end

		for (ph = 0; ph < 10; ph++) begin
			@(negedge clk);
			start <= 1'b0;
			typed_now = 1'b0;
			drain();
			case (ph)
				1: begin
					reg_write(bwd_pkg::REG_Y_MIN, 32'd0);
					reg_write(bwd_pkg::REG_Y_MAX, 32'h7fff_ffff);
					reg_write(bwd_pkg::REG_TIME_STEP, 32'h7fff_ffff);
					reg_write(bwd_pkg::REG_OMEGA_SHIFT, 32'h8000_0000);
				end
				2: begin
					reg_write(bwd_pkg::REG_Y_MIN, 32'h7fff_ffff);
					reg_write(bwd_pkg::REG_Y_MAX, 32'd0);
					reg_write(bwd_pkg::REG_TIME_STEP, 32'd66);
					reg_write(bwd_pkg::REG_OMEGA_SHIFT, 32'h7fff_ffff);
				end
				3: begin
					reg_write(bwd_pkg::REG_Y_MIN, 32'd32768);
					reg_write(bwd_pkg::REG_Y_MAX, 32'd163840);
					reg_write(bwd_pkg::REG_TIME_STEP, 32'd0);
					reg_write(bwd_pkg::REG_OMEGA_SHIFT, 32'h7fff_ffff);
				end
				default: begin
					reg_write(bwd_pkg::REG_Y_MIN, $urandom_range(0, 32'h0010_0000));
					reg_write(bwd_pkg::REG_Y_MAX, cfg_y_min + $urandom_range(0, 32'h0100_0000));
					reg_write(bwd_pkg::REG_TIME_STEP, $urandom_range(0, 3) == 0 ?
						$urandom & 32'h7fff_ffff : $urandom_range(0, 32'h0002_0000));
					reg_write(bwd_pkg::REG_OMEGA_SHIFT, rand_word());
				end
			endcase
			reg_write(bwd_pkg::REG_DAMP_AZ, ph < 4 ? (ph & 1) : $urandom_range(0, 1));
			reg_write(bwd_pkg::REG_DAMP_DENS,
				ph < 4 ? ((ph >> 1) & 1) : $urandom_range(0, 1));
			no_idle = (ph == 5);
			for (n = 0; n < 180; n++)
				send_cell(rand_cell(), 1'b0, '0);
		end

		@(negedge clk);
		start <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bwd_pkg.sv
rtl/boundary_wave_damping.sv
bench/tb_top.sv
